// ----- rtl/lpm_pkg.sv -----
// Shared widths, codes and constants for the laser power modulator.
// No dependencies; imported by rtl/laser_power_modulator.sv.
package lpm_pkg;

   // Field widths of the request, response and register words
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned REQ_W      = 12;
   localparam int unsigned RATE_W     = 20;
   localparam int unsigned STEPS_W    = 24;
   localparam int unsigned FIRE_W     = 14;
   localparam int unsigned PWR_W      = 17;
   localparam int unsigned SCALE_W    = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 17;

   // Axes taken into account, and axis ports on the request word
   localparam int unsigned AXES       = 3;
   localparam int unsigned AXIS_PORTS = 3;
   localparam int unsigned AXIS_IDX_W = 2;

   // Datapath widths
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned NUM_W      = REQ_W + RATE_W + SCALE_W;
   localparam int unsigned DBASE_W    = REQ_W + RATE_W;
   localparam int unsigned DEN_SCALE  = 100;
   localparam int unsigned DEN_W      = DBASE_W + 7;
   localparam int unsigned Q_W        = 35;
   localparam int unsigned PROD_W     = Q_W + PWR_W;
   localparam int unsigned MP_W       = RATE_W;
   localparam int unsigned TMAG_W     = PROD_W + 1 - FRAC_W;
   localparam int unsigned CNT_W      = $clog2(Q_W);

   // Constants
   localparam logic [PWR_W-1:0]   FULL_Q16   = 17'h1_0000;
   localparam logic [Q_W-1:0]     P_CAP      = 35'h4_0000_0000;
   localparam logic [FIRE_W-1:0]  FIRE_MAX   = 14'd10000;
   localparam logic [DEN_W-1:0]   FIRE_DEN   = 39'd10000;
   localparam logic [FRAC_W:0]    ROUND_UP   = 17'h0_FFFF;

   // Register reset values
   localparam logic [PWR_W-1:0]   MAX_POWER_RST = 17'h1_0000;
   localparam logic [PWR_W-1:0]   MIN_POWER_RST = 17'h0_0000;
   localparam logic [REQ_W-1:0]   MAX_REQ_RST   = 12'd2048;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 8'd100;

   // Request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_FIRE     = 2'd1,
      FUNC_HALT_SET = 2'd2,
      FUNC_HALT_CLR = 2'd3
   } func_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_POWER   = 3'd0,
      CSR_MIN_POWER   = 3'd1,
      CSR_MAX_REQUEST = 3'd2,
      CSR_SCALE       = 3'd3,
      CSR_INVERT      = 3'd4,
      CSR_ENABLE_USED = 3'd5
   } csr_type;

endpackage

// ----- rtl/laser_power_modulator.sv -----
// Laser power modulator: one response word per request word.
// The longest path, a tick with a cutting move, runs shift-add multiplies over the multiplier
// bits and a 35-step restoring divider; a fire word runs the divider alone, other words skip
// both, and a stalled response holds the finished word in ST_DONE until the output frees.
// Throughput: one request word at a time, taken once the sequencer is idle; a finished
// response waits in the output register meanwhile. Reset (sync, active high): flags clear.
module laser_power_modulator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lpm_pkg::FUNC_W-1:0]      req_func,
   input  logic                            req_move_active,
   input  logic [lpm_pkg::REQ_W-1:0]       req_power_request,
   input  logic [lpm_pkg::RATE_W-1:0]      req_plan_rate,
   input  logic [lpm_pkg::STEPS_W-1:0]     req_axis0_steps,
   input  logic [lpm_pkg::STEPS_W-1:0]     req_axis1_steps,
   input  logic [lpm_pkg::STEPS_W-1:0]     req_axis2_steps,
   input  logic [lpm_pkg::RATE_W-1:0]      req_axis0_rate,
   input  logic [lpm_pkg::RATE_W-1:0]      req_axis1_rate,
   input  logic [lpm_pkg::RATE_W-1:0]      req_axis2_rate,
   input  logic [lpm_pkg::FIRE_W-1:0]      req_fire_power,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lpm_pkg::PWR_W-1:0]       rsp_duty,
   output logic                            rsp_enable_level,
   output logic                            rsp_beam_on,
   output logic                            rsp_manual_mode,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lpm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEL, ST_MUL_A, ST_MUL_B, ST_DIV_INIT, ST_DIV_CHK, ST_DIV,
      ST_DIV_END, ST_MUL_C, ST_FIN_T, ST_FIN_V, ST_APPLY, ST_DONE
   } state_type;

   // Control state
   state_type              state_ff, state_in;
   logic                   beam_ff, beam_in;
   logic                   manual_ff, manual_in;
   logic                   halted_ff, halted_in;
   logic [PWR_W-1:0]       duty_ff, duty_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Registers
   logic [PWR_W-1:0]       max_power_ff, max_power_in;
   logic [PWR_W-1:0]       min_power_ff, min_power_in;
   logic [REQ_W-1:0]       max_req_ff, max_req_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic                   invert_ff, invert_in;
   logic                   en_used_ff, en_used_in;

   // Datapath
   logic                   fire_ff, fire_in;
   logic [AXIS_IDX_W-1:0]  ax_ff, ax_in;
   logic [AXIS_IDX_W-1:0]  pm_ff, pm_in;
   logic [STEPS_W-1:0]     best_ff, best_in;
   logic [REQ_W-1:0]       req_ff, req_in;
   logic [STEPS_W-1:0]     steps_ff [AXIS_PORTS];
   logic [STEPS_W-1:0]     steps_in [AXIS_PORTS];
   logic [RATE_W-1:0]      rates_ff [AXIS_PORTS];
   logic [RATE_W-1:0]      rates_in [AXIS_PORTS];
   logic [PROD_W-1:0]      mc_ff, mc_in;
   logic [MP_W-1:0]        mp_ff, mp_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [DBASE_W-1:0]     dmc_ff, dmc_in;
   logic [REQ_W-1:0]       dmp_ff, dmp_in;
   logic [DBASE_W-1:0]     dacc_ff, dacc_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [Q_W-1:0]         dvd_ff, dvd_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TMAG_W-1:0]      tmag_ff, tmag_in;
   logic [PWR_W-1:0]       pwr_ff, pwr_in;
   logic [PWR_W-1:0]       rsp_duty_ff, rsp_duty_in;
   logic                   rsp_en_ff, rsp_en_in;
   logic                   rsp_beam_ff, rsp_beam_in;
   logic                   rsp_manual_ff, rsp_manual_in;

   // Combinational helpers
   logic                   req_accept;
   logic                   csr_write;
   logic                   rsp_free;
   logic [PWR_W-1:0]       mx_lim, mn_lim;
   logic                   diff_neg;
   logic [PWR_W-1:0]       diff_mag;
   logic [FIRE_W-1:0]      fire_lim;
   logic [DEN_W:0]         trial;
   logic                   qbit;
   logic [Q_W-1:0]         q_capped;
   logic [PROD_W:0]        round_sum;
   logic [TMAG_W:0]        pos_sum;
   logic [TMAG_W-1:0]      mn_ext;

   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Limit the power registers and form the span between them
   assign mx_lim   = (max_power_ff > FULL_Q16) ? FULL_Q16 : max_power_ff;
   assign mn_lim   = (min_power_ff > FULL_Q16) ? FULL_Q16 : min_power_ff;
   assign diff_neg = mn_lim > mx_lim;
   assign diff_mag = diff_neg ? (mn_lim - mx_lim) : (mx_lim - mn_lim);
   assign fire_lim = (req_fire_power > FIRE_MAX) ? FIRE_MAX : req_fire_power;

   // One restoring divider step: bring down one dividend bit, try the subtract
   assign trial    = {rem_ff, dvd_ff[Q_W-1]};
   assign qbit     = trial >= {1'b0, den_ff};
   assign q_capped = (dvd_ff > P_CAP) ? P_CAP : dvd_ff;

   // Truncate toward zero for a positive span, round magnitude up for a negative one
   assign round_sum = {1'b0, acc_ff} + (diff_neg ? (PROD_W + 1)'(ROUND_UP) : '0);
   assign mn_ext    = TMAG_W'(mn_lim);
   assign pos_sum   = {1'b0, tmag_ff} + {1'b0, mn_ext};

   always_comb begin
      state_in      = state_ff;
      beam_in       = beam_ff;
      manual_in     = manual_ff;
      halted_in     = halted_ff;
      duty_in       = duty_ff;
      max_power_in  = max_power_ff;
      min_power_in  = min_power_ff;
      max_req_in    = max_req_ff;
      scale_in      = scale_ff;
      invert_in     = invert_ff;
      en_used_in    = en_used_ff;
      fire_in       = fire_ff;
      ax_in         = ax_ff;
      pm_in         = pm_ff;
      best_in       = best_ff;
      req_in        = req_ff;
      steps_in      = steps_ff;
      rates_in      = rates_ff;
      mc_in         = mc_ff;
      mp_in         = mp_ff;
      acc_in        = acc_ff;
      dmc_in        = dmc_ff;
      dmp_in        = dmp_ff;
      dacc_in       = dacc_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      tmag_in       = tmag_ff;
      pwr_in        = pwr_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_en_in     = rsp_en_ff;
      rsp_beam_in   = rsp_beam_ff;
      rsp_manual_in = rsp_manual_ff;

      // Drop the response word once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Take register writes
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_POWER:   max_power_in = csr_data[PWR_W-1:0];
            CSR_MIN_POWER:   min_power_in = csr_data[PWR_W-1:0];
            CSR_MAX_REQUEST: max_req_in   = csr_data[REQ_W-1:0];
            CSR_SCALE:       scale_in     = csr_data[SCALE_W-1:0];
            CSR_INVERT:      invert_in    = csr_data[0];
            CSR_ENABLE_USED: en_used_in   = csr_data[0];
            default:         ;
         endcase
      end

      // Advance the denominator multiplier (planned rate times max request) one bit
      if (dmp_ff != '0) begin
         if (dmp_ff[0]) begin
            dacc_in = dacc_ff + dmc_ff;
         end
         dmc_in = {dmc_ff[DBASE_W-2:0], 1'b0};
         dmp_in = {1'b0, dmp_ff[REQ_W-1:1]};
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               fire_in     = 1'b0;
               ax_in       = '0;
               pm_in       = '0;
               best_in     = '0;
               req_in      = req_power_request;
               steps_in[0] = req_axis0_steps;
               steps_in[1] = req_axis1_steps;
               steps_in[2] = req_axis2_steps;
               rates_in[0] = req_axis0_rate;
               rates_in[1] = req_axis1_rate;
               rates_in[2] = req_axis2_rate;
               dmc_in      = DBASE_W'(req_plan_rate);
               dmp_in      = max_req_ff;
               dacc_in     = '0;
               case (req_func)
                  FUNC_TICK: begin
                     if (manual_ff) begin
                        state_in = ST_DONE;
                     end else if (req_move_active) begin
                        if (req_plan_rate == '0 || max_req_ff == '0) begin
                           pwr_in   = '0;
                           state_in = ST_APPLY;
                        end else begin
                           state_in = ST_SEL;
                        end
                     end else if (beam_ff) begin
                        pwr_in   = '0;
                        state_in = ST_APPLY;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  FUNC_FIRE: begin
                     if (halted_ff) begin
                        state_in = ST_DONE;
                     end else begin
                        fire_in  = 1'b1;
                        rem_in   = '0;
                        dvd_in   = Q_W'({fire_lim, FRAC_W'(0)});
                        den_in   = FIRE_DEN;
                        cnt_in   = CNT_W'(Q_W - 1);
                        state_in = ST_DIV;
                     end
                  end
                  FUNC_HALT_SET: begin
                     pwr_in    = '0;
                     manual_in = 1'b0;
                     halted_in = 1'b1;
                     state_in  = ST_APPLY;
                  end
                  FUNC_HALT_CLR: begin
                     halted_in = 1'b0;
                     state_in  = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         // Scan the axes for the most steps; ties keep the lower axis
         ST_SEL: begin
            if (steps_ff[ax_ff] > best_ff) begin
               best_in = steps_ff[ax_ff];
               pm_in   = ax_ff;
            end
            if (ax_ff == AXIS_IDX_W'(AXES - 1)) begin
               mc_in    = PROD_W'(req_ff);
               mp_in    = MP_W'(scale_ff);
               acc_in   = '0;
               state_in = ST_MUL_A;
            end else begin
               ax_in = ax_ff + 1'b1;
            end
         end

         // Request times scale, one multiplier bit per cycle
         ST_MUL_A: begin
            if (mp_ff != '0) begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = {mc_ff[PROD_W-2:0], 1'b0};
               mp_in = {1'b0, mp_ff[MP_W-1:1]};
            end else begin
               mc_in    = acc_ff;
               mp_in    = rates_ff[pm_ff];
               acc_in   = '0;
               state_in = ST_MUL_B;
            end
         end

         // Then times the chosen axis rate
         ST_MUL_B: begin
            if (mp_ff != '0) begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = {mc_ff[PROD_W-2:0], 1'b0};
               mp_in = {1'b0, mp_ff[MP_W-1:1]};
            end else begin
               state_in = ST_DIV_INIT;
            end
         end

         // Load the divider with numerator times 2^16 once the denominator is done
         ST_DIV_INIT: begin
            if (dmp_ff == '0) begin
               den_in   = DEN_W'(dacc_ff) * DEN_W'(DEN_SCALE);
               rem_in   = DEN_W'(acc_ff[NUM_W-1:Q_W-FRAC_W]);
               dvd_in   = {acc_ff[Q_W-FRAC_W-1:0], FRAC_W'(0)};
               state_in = ST_DIV_CHK;
            end
         end

         // A quotient of 2^35 or more saturates without dividing
         ST_DIV_CHK: begin
            if (rem_ff >= den_ff) begin
               mc_in    = PROD_W'(P_CAP);
               mp_in    = MP_W'(diff_mag);
               acc_in   = '0;
               state_in = ST_MUL_C;
            end else begin
               cnt_in   = CNT_W'(Q_W - 1);
               state_in = ST_DIV;
            end
         end

         // One quotient bit per cycle
         ST_DIV: begin
            rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            dvd_in = {dvd_ff[Q_W-2:0], qbit};
            if (cnt_ff == '0) begin
               state_in = ST_DIV_END;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         ST_DIV_END: begin
            if (fire_ff) begin
               pwr_in   = dvd_ff[PWR_W-1:0];
               state_in = ST_APPLY;
            end else begin
               mc_in    = PROD_W'(q_capped);
               mp_in    = MP_W'(diff_mag);
               acc_in   = '0;
               state_in = ST_MUL_C;
            end
         end

         // Span magnitude times the speed-scaled fraction
         ST_MUL_C: begin
            if (mp_ff != '0) begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = {mc_ff[PROD_W-2:0], 1'b0};
               mp_in = {1'b0, mp_ff[MP_W-1:1]};
            end else begin
               state_in = ST_FIN_T;
            end
         end

         ST_FIN_T: begin
            tmag_in  = round_sum[PROD_W:FRAC_W];
            state_in = ST_FIN_V;
         end

         // Offset from minimum power and clamp to 0..full
         ST_FIN_V: begin
            if (diff_neg) begin
               pwr_in = (tmag_ff >= mn_ext) ? '0 : PWR_W'(mn_ext - tmag_ff);
            end else begin
               pwr_in = (pos_sum > (TMAG_W + 1)'(FULL_Q16)) ? FULL_Q16 : pos_sum[PWR_W-1:0];
            end
            state_in = ST_APPLY;
         end

         // Drive the duty, with inversion, the beam flag and, for a fire word, the manual flag
         ST_APPLY: begin
            if (pwr_ff != '0) begin
               duty_in = invert_ff ? (FULL_Q16 - pwr_ff) : pwr_ff;
               beam_in = 1'b1;
            end else begin
               duty_in = invert_ff ? FULL_Q16 : '0;
               beam_in = 1'b0;
            end
            if (fire_ff) begin
               manual_in = pwr_ff != '0;
            end
            state_in = ST_DONE;
         end

         // Hand the response word to the output register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_duty_in   = duty_ff;
               rsp_en_in     = en_used_ff && beam_ff;
               rsp_beam_in   = beam_ff;
               rsp_manual_in = manual_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state, registers and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         beam_ff       <= 1'b0;
         manual_ff     <= 1'b0;
         halted_ff     <= 1'b0;
         duty_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_duty_ff   <= '0;
         rsp_en_ff     <= 1'b0;
         rsp_beam_ff   <= 1'b0;
         rsp_manual_ff <= 1'b0;
         max_power_ff  <= MAX_POWER_RST;
         min_power_ff  <= MIN_POWER_RST;
         max_req_ff    <= MAX_REQ_RST;
         scale_ff      <= SCALE_RST;
         invert_ff     <= 1'b0;
         en_used_ff    <= 1'b0;
         dmp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         beam_ff       <= beam_in;
         manual_ff     <= manual_in;
         halted_ff     <= halted_in;
         duty_ff       <= duty_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_duty_ff   <= rsp_duty_in;
         rsp_en_ff     <= rsp_en_in;
         rsp_beam_ff   <= rsp_beam_in;
         rsp_manual_ff <= rsp_manual_in;
         max_power_ff  <= max_power_in;
         min_power_ff  <= min_power_in;
         max_req_ff    <= max_req_in;
         scale_ff      <= scale_in;
         invert_ff     <= invert_in;
         en_used_ff    <= en_used_in;
         dmp_ff        <= dmp_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      fire_ff       <= fire_in;
      ax_ff         <= ax_in;
      pm_ff         <= pm_in;
      best_ff       <= best_in;
      req_ff        <= req_in;
      steps_ff      <= steps_in;
      rates_ff      <= rates_in;
      mc_ff         <= mc_in;
      mp_ff         <= mp_in;
      acc_ff        <= acc_in;
      dmc_ff        <= dmc_in;
      dacc_ff       <= dacc_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      den_ff        <= den_in;
      cnt_ff        <= cnt_in;
      tmag_ff       <= tmag_in;
      pwr_ff        <= pwr_in;
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_enable_level = rsp_en_ff;
   assign rsp_beam_on      = rsp_beam_ff;
   assign rsp_manual_mode  = rsp_manual_ff;

   // An accepted word keeps the sequencer busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted while sequencer did not go busy");

   // Manual mode only stands with the beam on
   a_manual_beam: assert property (@(posedge clock) disable iff (reset)
      manual_ff |-> beam_ff)
      else $error("manual mode without beam");

   // Divider partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < den_ff)
      else $error("divider remainder out of range");

   // Power applied is never above full duty
   a_pwr_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |-> pwr_ff <= FULL_Q16)
      else $error("power above full duty");

endmodule
